// ----- hdl/sptw_pkg.sv -----
package sptw_pkg;

  // Result kinds
  localparam logic [1:0] KIND_XLATE    = 2'd0;
  localparam logic [1:0] KIND_FAULT    = 2'd1;
  localparam logic [1:0] KIND_PTE_RD   = 2'd2;
  localparam logic [1:0] KIND_PTE_WR   = 2'd3;

  // Input modes
  localparam logic MODE_REQ = 1'b0;
  localparam logic MODE_RSP = 1'b1;

  // Access kinds
  localparam logic [1:0] ACC_READ  = 2'd0;
  localparam logic [1:0] ACC_WRITE = 2'd1;
  localparam logic [1:0] ACC_FETCH = 2'd2;

  // Privilege levels
  localparam logic [1:0] PRIV_USER = 2'd0;
  localparam logic [1:0] PRIV_SUPV = 2'd1;

  // Configuration register indexes
  localparam logic [1:0] REG_PAGING = 2'd0;
  localparam logic [1:0] REG_ROOT   = 2'd1;
  localparam logic [1:0] REG_MXR    = 2'd2;
  localparam logic [1:0] REG_SUM    = 2'd3;

  // PTE bit positions
  localparam int PTE_V = 0;
  localparam int PTE_R = 1;
  localparam int PTE_W = 2;
  localparam int PTE_X = 3;
  localparam int PTE_U = 4;
  localparam int PTE_A = 6;
  localparam int PTE_D = 7;

  // Results produced per input
  localparam logic [1:0] NRES_NONE = 2'd0;
  localparam logic [1:0] NRES_ONE  = 2'd1;
  localparam logic [1:0] NRES_TWO  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        user_page;
    logic [2:0]  page_permissions;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        paging_enable;
    logic [21:0] root_table_page;
    logic        make_exec_readable;
    logic        supervisor_user_access;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic step;         // beat accepted: update walk state, capture second result
    logic load_first;   // output register takes first result
    logic load_second;  // output register takes held second result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] n_res;
  } sts_t;

endpackage

// ----- hdl/sv32_page_table_walker.sv -----
// Sv32 two-level page-table walker. Each input beat is either a translate
// request or the memory's reply to the last PTE read; each beat yields zero,
// one or two result beats (translated address, page fault, PTE read request,
// or PTE write-back followed by the translated address on a successful leaf).
// The walker issues memory reads and write-backs as result beats and waits for
// the caller to feed the PTE back in; it holds one walk at a time and a new
// request abandons any walk in flight. Rate: one input beat per cycle while
// each beat gives at most one result and the output does not stall; a leaf
// hit gives two beats and holds off input for the second. The single output
// register sets this figure. Memory latency, not the logic, paces a walk.
// Configuration (APB, byte addresses 0x0/0x4/0x8/0xC: paging enable, root PPN,
// MXR, SUM) is sampled on every beat and should be written while idle.
module sv32_page_table_walker
  import sptw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [31:0] in_virtual_address,
  input  logic [1:0]  in_access_kind,
  input  logic [1:0]  in_privilege,
  input  logic [31:0] in_pte_word,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_address,
  output logic [31:0] out_write_data,
  output logic        out_user_page,
  output logic [2:0]  out_page_permissions,
  output logic        out_last
);

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  cmd_t       cmd;
  sts_t       sts;
  res_t       res;

  // ---- configuration registers ----
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PAGING: cfg_r.paging_enable          <= pwdata[0];
        REG_ROOT:   cfg_r.root_table_page        <= pwdata[21:0];
        REG_MXR:    cfg_r.make_exec_readable     <= pwdata[0];
        REG_SUM:    cfg_r.supervisor_user_access <= pwdata[0];
        default:    cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PAGING: prdata = {31'd0, cfg_r.paging_enable};
      REG_ROOT:   prdata = {10'd0, cfg_r.root_table_page};
      REG_MXR:    prdata = {31'd0, cfg_r.make_exec_readable};
      REG_SUM:    prdata = {31'd0, cfg_r.supervisor_user_access};
      default:    prdata = 32'd0;
    endcase
  end

  // ---- handshake control: output register plus second-result hold ----
  sptw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // ---- walk state, PTE checks and result formation ----
  sptw_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .cmd                (cmd),
    .in_mode            (in_mode),
    .in_virtual_address (in_virtual_address),
    .in_access_kind     (in_access_kind),
    .in_privilege       (in_privilege),
    .in_pte_word        (in_pte_word),
    .sts                (sts),
    .out_res            (res)
  );

  assign out_kind             = res.kind;
  assign out_address          = res.address;
  assign out_write_data       = res.write_data;
  assign out_user_page        = res.user_page;
  assign out_page_permissions = res.page_permissions;
  assign out_last             = res.last;

endmodule

// ----- hdl/sptw_dp.sv -----
module sptw_dp
  import sptw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  input  logic        in_mode,
  input  logic [31:0] in_virtual_address,
  input  logic [1:0]  in_access_kind,
  input  logic [1:0]  in_privilege,
  input  logic [31:0] in_pte_word,
  output sts_t        sts,
  output res_t        out_res
);

  logic        busy_r, busy_nxt;
  logic        level_r, level_nxt;
  logic [31:0] vaddr_r, vaddr_nxt;
  logic [1:0]  acc_r, acc_nxt;
  logic [1:0]  priv_r, priv_nxt;
  logic [31:0] pte_addr_r, pte_addr_nxt;
  res_t        hold_r;
  res_t        out_r;

  res_t        r1, r2;
  logic [1:0]  n_res;

  logic        pte_v, pte_r, pte_w, pte_x, pte_u;
  logic        perm_ok, leaf_ok;
  logic [31:0] upd;
  logic [31:0] pa;

  assign pte_v = in_pte_word[PTE_V];
  assign pte_r = in_pte_word[PTE_R];
  assign pte_w = in_pte_word[PTE_W];
  assign pte_x = in_pte_word[PTE_X];
  assign pte_u = in_pte_word[PTE_U];

  always_comb begin
    case (acc_r)
      ACC_READ:  perm_ok = pte_r | (pte_x & cfg.make_exec_readable);
      ACC_WRITE: perm_ok = pte_w;
      ACC_FETCH: perm_ok = pte_x;
      default:   perm_ok = 1'b0;
    endcase
  end

  // Permission, SUM check and superpage alignment
  assign leaf_ok = perm_ok
                 && !(priv_r == PRIV_SUPV && pte_u && !cfg.supervisor_user_access)
                 && !(level_r && (in_pte_word[19:10] != 10'd0));

  always_comb begin
    upd = in_pte_word;
    upd[PTE_A] = 1'b1;
    if (acc_r == ACC_WRITE) begin
      upd[PTE_D] = 1'b1;
    end
  end

  // superpage keeps VPN[0] from the virtual address
  assign pa = level_r ? {upd[29:20], vaddr_r[21:0]} : {upd[29:10], vaddr_r[11:0]};

  always_comb begin
    busy_nxt     = busy_r;
    level_nxt    = level_r;
    vaddr_nxt    = vaddr_r;
    acc_nxt      = acc_r;
    priv_nxt     = priv_r;
    pte_addr_nxt = pte_addr_r;
    n_res        = NRES_NONE;
    r1           = '0;
    r1.last      = 1'b1;
    r2           = '0;
    r2.kind      = KIND_XLATE;
    r2.address   = pa;
    r2.user_page = upd[PTE_U];
    r2.page_permissions = upd[3:1];
    r2.last      = 1'b1;

    if (in_mode == MODE_REQ) begin
      n_res     = NRES_ONE;
      level_nxt = 1'b1;
      if (!cfg.paging_enable || in_privilege > PRIV_SUPV) begin
        busy_nxt   = 1'b0;
        r1.kind    = KIND_XLATE;
        r1.address = in_virtual_address;
      end else begin
        busy_nxt     = 1'b1;
        vaddr_nxt    = in_virtual_address;
        acc_nxt      = in_access_kind;
        priv_nxt     = in_privilege;
        pte_addr_nxt = {cfg.root_table_page[19:0], in_virtual_address[31:22], 2'b00};
        r1.kind      = KIND_PTE_RD;
        r1.address   = pte_addr_nxt;
      end
    end else if (busy_r) begin
      n_res      = NRES_ONE;
      r1.kind    = KIND_FAULT;
      r1.address = vaddr_r;
      busy_nxt   = 1'b0;
      level_nxt  = 1'b1;
      if (!pte_v || (!pte_r && pte_w)) begin
        // invalid or reserved encoding: fault
      end else if (!pte_r && !pte_x) begin
        if (level_r) begin
          busy_nxt     = 1'b1;
          level_nxt    = 1'b0;
          pte_addr_nxt = {in_pte_word[29:10], vaddr_r[21:12], 2'b00};
          r1.kind      = KIND_PTE_RD;
          r1.address   = pte_addr_nxt;
        end
      end else if (leaf_ok) begin
        n_res         = NRES_TWO;
        r1.kind       = KIND_PTE_WR;
        r1.address    = pte_addr_r;
        r1.write_data = upd;
        r1.last       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      level_r <= 1'b1;
    end else if (cmd.step) begin
      busy_r  <= busy_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      vaddr_r    <= vaddr_nxt;
      acc_r      <= acc_nxt;
      priv_r     <= priv_nxt;
      pte_addr_r <= pte_addr_nxt;
      hold_r     <= r2;
    end
    if (cmd.load_first) begin
      out_r <= r1;
    end else if (cmd.load_second) begin
      out_r <= hold_r;
    end
  end

  assign sts.n_res = n_res;
  assign out_res   = out_r;

endmodule

// ----- hdl/sptw_ctrl.sv -----
module sptw_ctrl
  import sptw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic ST_RUN    = 1'b0;
  localparam logic ST_SECOND = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;
  logic accept;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_RUN) && slot_free;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    cmd             = '0;
    cmd.step        = accept;
    unique case (state_r)
      ST_RUN: begin
        if (accept) begin
          cmd.load_first = (sts.n_res != NRES_NONE);
          out_valid_nxt  = (sts.n_res != NRES_NONE);
          if (sts.n_res == NRES_TWO) begin
            state_nxt = ST_SECOND;
          end
        end else if (out_ready) begin
          out_valid_nxt = 1'b0;
        end
      end
      ST_SECOND: begin
        if (slot_free) begin
          cmd.load_second = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_second_has_first: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SECOND |-> out_valid_r)
    else $error("second result pending without first result shown");

  a_two_goes_second: assert property (@(posedge clk) disable iff (!rst_n)
    accept && sts.n_res == NRES_TWO |=> state_r == ST_SECOND && out_valid_r)
    else $error("two-result beat did not enter second-result state");

  a_none_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && sts.n_res == NRES_NONE |=> !out_valid_r)
    else $error("ignored response produced a result");

  a_no_load_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_first && cmd.load_second))
    else $error("output register loaded from both sources");

endmodule

// ----- test/sptw_walk_checker.sv -----
module sptw_walk_checker
  import sptw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_mode,
  input  logic [31:0] in_virtual_address,
  input  logic [1:0]  in_access_kind,
  input  logic [1:0]  in_privilege,
  input  logic [31:0] in_pte_word,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_address,
  input  logic [31:0] out_write_data,
  input  logic        out_user_page,
  input  logic [2:0]  out_page_permissions,
  input  logic        out_last,

  output int unsigned results_owed,
  output int unsigned error_total
);

  cfg_t        cfg;
  logic        walking;
  logic        at_root;      // 1: next PTE is from the root table
  logic [31:0] walk_va;
  logic [1:0]  walk_acc;
  logic [1:0]  walk_priv;
  logic [31:0] entry_addr;
  res_t        owed[$];
  res_t        due;
  int unsigned errors;

  function automatic void owe(logic [1:0] kind, logic [31:0] addr, logic [31:0] wdata,
                              logic user, logic [2:0] perms, logic last);
    res_t r;
    r.kind             = kind;
    r.address          = addr;
    r.write_data       = wdata;
    r.user_page        = user;
    r.page_permissions = perms;
    r.last             = last;
    owed.push_back(r);
  endfunction

  function automatic void end_walk_fault();
    owe(KIND_FAULT, walk_va, '0, 1'b0, 3'b000, 1'b1);
    walking = 1'b0;
    at_root = 1'b1;
  endfunction

  function automatic logic leaf_grants(logic [31:0] pte);
    logic ok;
    case (walk_acc)
      ACC_READ:  ok = pte[PTE_R] || (pte[PTE_X] && cfg.make_exec_readable);
      ACC_WRITE: ok = pte[PTE_W];
      ACC_FETCH: ok = pte[PTE_X];
      default:   ok = 1'b0;
    endcase
    if (walk_priv == PRIV_SUPV && pte[PTE_U] && !cfg.supervisor_user_access)
      ok = 1'b0;
    // superpage must be aligned on PPN[0]
    if (at_root && pte[19:10] != '0)
      ok = 1'b0;
    return ok;
  endfunction

  function automatic void predict_walk_beat(logic mode, logic [31:0] va, logic [1:0] acc,
                                            logic [1:0] priv, logic [31:0] pte);
    logic [31:0] upd;
    logic [31:0] pa;
    if (mode == MODE_REQ) begin
      if (!cfg.paging_enable || priv > PRIV_SUPV) begin
        walking = 1'b0;
        at_root = 1'b1;
        owe(KIND_XLATE, va, '0, 1'b0, 3'b000, 1'b1);
      end else begin
        walking    = 1'b1;
        at_root    = 1'b1;
        walk_va    = va;
        walk_acc   = acc;
        walk_priv  = priv;
        entry_addr = {cfg.root_table_page[19:0], 12'h000} + {20'h0, va[31:22], 2'b00};
        owe(KIND_PTE_RD, entry_addr, '0, 1'b0, 3'b000, 1'b1);
      end
    end else if (walking) begin
      if (!pte[PTE_V] || (!pte[PTE_R] && pte[PTE_W])) begin
        end_walk_fault();
      end else if (!pte[PTE_R] && !pte[PTE_X]) begin
        if (!at_root) begin
          end_walk_fault();
        end else begin
          at_root    = 1'b0;
          entry_addr = {pte[29:10], 12'h000} + {20'h0, walk_va[21:12], 2'b00};
          owe(KIND_PTE_RD, entry_addr, '0, 1'b0, 3'b000, 1'b1);
        end
      end else if (!leaf_grants(pte)) begin
        end_walk_fault();
      end else begin
        upd        = pte;
        upd[PTE_A] = 1'b1;
        if (walk_acc == ACC_WRITE)
          upd[PTE_D] = 1'b1;
        pa = {upd[29:10], walk_va[11:0]};
        if (at_root)
          pa[21:12] = walk_va[21:12];
        owe(KIND_PTE_WR, entry_addr, upd, 1'b0, 3'b000, 1'b0);
        owe(KIND_XLATE, pa, '0, upd[PTE_U], {upd[PTE_X], upd[PTE_W], upd[PTE_R]}, 1'b1);
        walking = 1'b0;
        at_root = 1'b1;
      end
    end
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg        = '0;
      walking    = 1'b0;
      at_root    = 1'b1;
      walk_va    = '0;
      walk_acc   = '0;
      walk_priv  = '0;
      entry_addr = '0;
      errors     = 0;
      owed.delete();
    end else begin
      if (in_valid && in_ready)
        predict_walk_beat(in_mode, in_virtual_address, in_access_kind, in_privilege,
                          in_pte_word);
      if (out_valid && out_ready) begin
        if (owed.size() == 0) begin
          errors++;
          $display("%0t: result beat expected none got kind %0d address %h", $time,
                   out_kind, out_address);
        end else begin
          due = owed.pop_front();
          check_field("kind", 32'(due.kind), 32'(out_kind));
          check_field("address", due.address, out_address);
          check_field("write_data", due.write_data, out_write_data);
          check_field("user_page", 32'(due.user_page), 32'(out_user_page));
          check_field("page_permissions", 32'(due.page_permissions),
                      32'(out_page_permissions));
          check_field("last", 32'(due.last), 32'(out_last));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PAGING: cfg.paging_enable          = pwdata[0];
          REG_ROOT:   cfg.root_table_page        = pwdata[21:0];
          REG_MXR:    cfg.make_exec_readable     = pwdata[0];
          REG_SUM:    cfg.supervisor_user_access = pwdata[0];
        endcase
      end
    end
    results_owed <= owed.size();
    error_total  <= errors;
  end

endmodule

// ----- test/tb.sv -----
module tb
  import sptw_pkg::*;
();

  // Codes the package leaves unnamed but the stimulus needs.
  localparam logic [1:0] ACC_NONE  = 2'd3;  // no permission bit grants it
  localparam logic [1:0] PRIV_HYP  = 2'd2;  // treated as machine mode
  localparam logic [1:0] PRIV_MACH = 2'd3;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned BEATS_PER_PHASE = 235;
  localparam int unsigned HOLD_AFTER      = 400;  // beats sent before the long output stall
  localparam int unsigned HOLD_CYCLES     = 400;

  // One input beat, either a translate request or a PTE reply.
  typedef struct packed {
    logic        mode;
    logic [31:0] va;
    logic [1:0]  acc;
    logic [1:0]  priv;
    logic [31:0] pte;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = MODE_REQ;
  logic [31:0] in_virtual_address = '0;
  logic [1:0]  in_access_kind = ACC_READ;
  logic [1:0]  in_privilege = PRIV_USER;
  logic [31:0] in_pte_word = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [31:0] out_address;
  logic [31:0] out_write_data;
  logic        out_user_page;
  logic [2:0]  out_page_permissions;
  logic        out_last;

  int unsigned results_owed;
  int unsigned error_total;

  int unsigned beats_sent = 0;  // input beats accepted so far
  int unsigned cycles = 0;
  bit          calm = 1'b0;     // set for the tail of the run: no idling on either side
  beat_t       walk_q[$];

  always #5 clk = ~clk;

  sv32_page_table_walker i_dut (.*);

  sptw_walk_checker i_checker (.*);

  // Hard stop in case the block hangs a handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random ready bursts, plus one long stall once traffic is
  // flowing so the single output register backs up into in_ready.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned span;
    bit          held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && beats_sent >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        span = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 7);
      end else begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 16);
      end
      repeat (span) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Beat builders. Fields the block ignores for a given mode carry random
  // junk so every input bit toggles.
  // ---------------------------------------------------------------------------
  function automatic beat_t request(logic [31:0] va, logic [1:0] acc, logic [1:0] priv);
    beat_t b;
    b.mode = MODE_REQ;
    b.va   = va;
    b.acc  = acc;
    b.priv = priv;
    b.pte  = $urandom;
    return b;
  endfunction

  function automatic beat_t reply(logic [31:0] pte);
    beat_t b;
    b.mode = MODE_RSP;
    b.va   = $urandom;
    b.acc  = 2'($urandom_range(0, 3));
    b.priv = 2'($urandom_range(0, 3));
    b.pte  = pte;
    return b;
  endfunction

  // Valid, non-leaf entry with random PPN and upper flag bits.
  function automatic logic [31:0] pointer_pte();
    logic [31:0] p;
    p = $urandom;
    p[PTE_X:PTE_V] = 4'b0001;
    return p;
  endfunction

  // Valid leaf. Mostly grants what the access needs; superpages mostly aligned.
  function automatic logic [31:0] leaf_pte(logic [1:0] acc, logic superpage);
    logic [31:0] p;
    p = $urandom;
    p[PTE_V] = 1'b1;
    do
      p[PTE_X:PTE_R] = 3'($urandom_range(1, 7));
    while (!p[PTE_R] && p[PTE_W]);
    if ($urandom_range(0, 3) != 0) begin
      case (acc)
        ACC_READ:  p[PTE_R] = 1'b1;
        ACC_WRITE: p[PTE_W:PTE_R] = 2'b11;
        ACC_FETCH: p[PTE_X] = 1'b1;
        default:   ;
      endcase
    end
    if (superpage && $urandom_range(0, 3) != 0)
      p[19:10] = '0;
    return p;
  endfunction

  // Queue one walk: mostly a request and well-formed replies with random
  // content; some abandoned walks, broken entries, stray replies and noise.
  task automatic queue_walk();
    logic [1:0]  acc;
    logic [1:0]  priv;
    int unsigned pick;
    acc  = ($urandom_range(0, 19) == 0) ? ACC_NONE : 2'($urandom_range(0, 2));
    priv = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(PRIV_HYP, PRIV_MACH))
                                       : 2'($urandom_range(PRIV_USER, PRIV_SUPV));
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      walk_q.push_back($urandom_range(0, 1) ? reply($urandom) : request($urandom, acc, priv));
      return;
    end
    walk_q.push_back(request($urandom, acc, priv));
    if (priv > PRIV_SUPV)
      return;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      return;  // next request abandons this walk
    end else if (pick < 18) begin
      walk_q.push_back(reply($urandom));
    end else if (pick < 50) begin
      walk_q.push_back(reply(leaf_pte(acc, 1'b1)));
    end else begin
      walk_q.push_back(reply(pointer_pte()));
      pick = $urandom_range(0, 9);
      if (pick < 8)
        walk_q.push_back(reply(leaf_pte(acc, 1'b0)));
      else if (pick < 9)
        walk_q.push_back(reply(pointer_pte()));  // pointer at the last level
      else
        walk_q.push_back(reply($urandom));
    end
    if ($urandom_range(0, 19) == 0)
      walk_q.push_back(reply($urandom));  // arrives while idle
  endtask

  // ---------------------------------------------------------------------------
  // Handshake drivers
  // ---------------------------------------------------------------------------
  task automatic drive_beat(beat_t b);
    in_valid           <= 1'b1;
    in_mode            <= b.mode;
    in_virtual_address <= b.va;
    in_access_kind     <= b.acc;
    in_privilege       <= b.priv;
    in_pte_word        <= b.pte;
    do @(posedge clk); while (!in_ready);
    beats_sent <= beats_sent + 1;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic drain_walks();
    while (walk_q.size() != 0)
      drive_beat(walk_q.pop_front());
  endtask

  // Stop offering beats until every predicted result is out, then give a
  // stray reply or a held second result time to clear.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (8) @(posedge clk);
  endtask

  // APB write; leaves psel up so back-to-back writes need no extra step.
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Unused upper bits carry junk; the registers keep only their own width.
  task automatic configure(logic paging, logic [21:0] root, logic mxr, logic sum);
    reg_write(REG_PAGING, ($urandom & 32'hffff_fffe) | {31'h0, paging});
    reg_write(REG_ROOT,   ($urandom & 32'hffc0_0000) | {10'h0, root});
    reg_write(REG_MXR,    ($urandom & 32'hffff_fffe) | {31'h0, mxr});
    reg_write(REG_SUM,    ($urandom & 32'hffff_fffe) | {31'h0, sum});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned ph;
    int unsigned target;
    logic [21:0] root;
    logic        mxr;
    logic        sum;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Paging off: everything passes straight through, replies are dropped.
    configure(1'b0, 22'h0, 1'b0, 1'b0);
    drive_beat(request(32'h0000_0000, ACC_READ, PRIV_USER));
    drive_beat(request(32'hffff_ffff, ACC_FETCH, PRIV_SUPV));
    drive_beat(reply(32'hffff_ffff));
    settle();

    // Top root page, so the root entry address wraps past 32 bits.
    configure(1'b1, 22'h3f_ffff, 1'b0, 1'b0);
    drive_beat(request(32'hffff_ffff, ACC_READ, PRIV_MACH));   // machine: no walk
    drive_beat(request(32'h1234_5678, ACC_WRITE, PRIV_HYP));   // also no walk
    // two-level walk to a user RWX page at the top of memory
    drive_beat(request(32'hffff_ffff, ACC_READ, PRIV_USER));
    drive_beat(reply(32'hffff_fc01));
    drive_beat(reply(32'hffff_fc1f));
    // aligned superpage, write sets D
    drive_beat(request(32'h0000_0000, ACC_WRITE, PRIV_SUPV));
    drive_beat(reply(32'hfff0_0007));
    // aligned execute-only superpage, fetch
    drive_beat(request(32'h0040_0000, ACC_FETCH, PRIV_USER));
    drive_beat(reply(32'h0010_0009));
    // invalid entry
    drive_beat(request(32'h8000_0abc, ACC_READ, PRIV_SUPV));
    drive_beat(reply(32'h0000_0000));
    // reserved W without R
    drive_beat(request(32'h7654_3210, ACC_READ, PRIV_USER));
    drive_beat(reply(32'h0000_0005));
    // pointer found at the last level
    drive_beat(request(32'h0123_4567, ACC_READ, PRIV_USER));
    drive_beat(reply(32'h0000_0001));
    drive_beat(reply(32'h0000_0401));
    // execute-only page read without MXR
    drive_beat(request(32'h0000_1000, ACC_READ, PRIV_USER));
    drive_beat(reply(32'h0000_0009));
    // access kind no leaf can grant
    drive_beat(request(32'h0000_2000, ACC_NONE, PRIV_USER));
    drive_beat(reply(32'h0000_001f));
    // supervisor touching a user page without SUM
    drive_beat(request(32'h0000_3000, ACC_READ, PRIV_SUPV));
    drive_beat(reply(32'h0000_0013));
    // request mid-walk abandons the first walk
    drive_beat(request(32'h0000_4000, ACC_READ, PRIV_USER));
    drive_beat(request(32'h0000_5000, ACC_READ, PRIV_USER));
    drive_beat(reply(32'h0000_0003));
    settle();

    // MXR and SUM both on turn the two faults above into hits.
    configure(1'b1, 22'h0, 1'b1, 1'b1);
    drive_beat(request(32'h0000_1000, ACC_READ, PRIV_USER));
    drive_beat(reply(32'h0000_0009));
    drive_beat(request(32'h0000_3000, ACC_READ, PRIV_SUPV));
    drive_beat(reply(32'h0000_0013));

    // Random phases, each under its own register setting. One phase runs
    // with paging off; the root page visits both extremes.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      root = (ph == 1) ? 22'h0 : (ph == 2) ? 22'h3f_ffff : 22'($urandom);
      mxr  = (ph == 4) ? 1'b1 : (ph == 5) ? 1'b0 : 1'($urandom_range(0, 1));
      sum  = (ph == 4) ? 1'b1 : (ph == 5) ? 1'b0 : 1'($urandom_range(0, 1));
      configure(ph != 3, root, mxr, sum);
      if (ph == RANDOM_PHASES - 1)
        calm = 1'b1;
      target = beats_sent + BEATS_PER_PHASE;
      while (beats_sent < target) begin
        queue_walk();
        drain_walks();
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (error_total == 0 && results_owed == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
